// ===== src/mpqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpqs_pkg: shared definitions for the scanning min priority queue
// Field widths, operation and status codes, and the response bundle.
// ----------------------------------------------------------------------------
package mpqs_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int MODE_W   = 2;
   localparam int ID_W     = 8;
   localparam int PRI_W    = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = ID_W + PRI_W;

   localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PEEK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POP  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     out_id;
      logic [PRI_W-1:0]    out_priority;
   } rsp_type;

endpackage
`default_nettype wire

// ===== src/mpqs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpqs_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/mpqs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpqs_ctrl: queue sequencer
// Keeps the entry count, appends pushes, scans the slot RAM for the minimum
// and compacts the RAM after a pop.
// ----------------------------------------------------------------------------
module mpqs_ctrl import mpqs_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [MODE_W-1:0]        mode,
   input  wire logic [ID_W-1:0]          entry_id,
   input  wire logic [PRI_W-1:0]         priority_req,
   output logic                          ram_wr_en,
   output logic      [$clog2(DEPTH)-1:0] ram_wr_addr,
   output logic      [SLOT_W-1:0]        ram_wr_data,
   output logic                          ram_rd_en,
   output logic      [$clog2(DEPTH)-1:0] ram_rd_addr,
   input  wire logic [SLOT_W-1:0]        ram_rd_data,
   output rsp_type                       rsp
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              is_pop_ff, is_pop_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;
   logic [PRI_W-1:0]  best_pri_ff, best_pri_in;

   logic [ID_W-1:0]   rd_id;
   logic [PRI_W-1:0]  rd_pri;
   logic              take;
   logic [ADDR_W-1:0] cand_idx;
   logic [ID_W-1:0]   cand_id;
   logic [PRI_W-1:0]  cand_pri;
   logic [CNT_W-1:0]  idx_ext;

   assign rd_id   = ram_rd_data[SLOT_W-1:PRI_W];
   assign rd_pri  = ram_rd_data[PRI_W-1:0];
   assign idx_ext = CNT_W'(idx_ff);

   // Slot 0 seeds the search; later slots win only when strictly lower,
   // so ties stay with the earliest slot.
   assign take     = (idx_ff == '0) || (rd_pri < best_pri_ff);
   assign cand_idx = take ? idx_ff : best_idx_ff;
   assign cand_id  = take ? rd_id  : best_id_ff;
   assign cand_pri = take ? rd_pri : best_pri_ff;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      is_pop_in   = is_pop_ff;
      idx_in      = idx_ff;
      last_in     = last_ff;
      best_idx_in = best_idx_ff;
      best_id_in  = best_id_ff;
      best_pri_in = best_pri_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      rsp         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (mode)
                  MODE_PUSH: begin
                     rsp.valid = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp.status = STATUS_FULL;
                     end else begin
                        rsp.status  = STATUS_OK;
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[ADDR_W-1:0];
                        ram_wr_data = {entry_id, priority_req};
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  MODE_PEEK, MODE_POP: begin
                     if (count_ff == '0) begin
                        rsp.valid  = 1'b1;
                        rsp.status = STATUS_EMPTY;
                     end else begin
                        // The newest entry is left out of the search unless
                        // it is the only one.
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        idx_in      = '0;
                        last_in     = (count_ff >= CNT_W'(2)) ?
                                      ADDR_W'(count_ff - CNT_W'(2)) : '0;
                        is_pop_in   = (mode == MODE_POP);
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp.valid  = 1'b1;
                     rsp.status = STATUS_OK;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            best_idx_in = cand_idx;
            best_id_in  = cand_id;
            best_pri_in = cand_pri;
            if (idx_ff != last_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(idx_ext + 1'b1);
               idx_in      = ADDR_W'(idx_ext + 1'b1);
            end else begin
               rsp.valid        = 1'b1;
               rsp.status       = STATUS_OK;
               rsp.out_id       = cand_id;
               rsp.out_priority = cand_pri;
               if (!is_pop_ff) begin
                  state_in = ST_IDLE;
               end else if (count_ff >= CNT_W'(2)) begin
                  // Move every later entry down one slot, starting at the
                  // slot just above the removed one.
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ADDR_W'(CNT_W'(cand_idx) + 1'b1);
                  idx_in      = cand_idx;
                  state_in    = ST_SHIFT;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = ram_rd_data;
            if (idx_ext + CNT_W'(2) == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(idx_ext + CNT_W'(2));
               idx_in      = ADDR_W'(idx_ext + 1'b1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      is_pop_ff   <= is_pop_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      best_idx_ff <= best_idx_in;
      best_id_ff  <= best_id_in;
      best_pri_ff <= best_pri_in;
   end

endmodule
`default_nettype wire

// ===== src/min_priority_queue_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_priority_queue_scan: unsorted priority queue with a linear minimum scan
// Entries live in arrival order in one slot RAM; peek and pop scan it.
// ----------------------------------------------------------------------------
// Every transaction returns exactly one response, shown on the rsp_ ports for
// a single cycle with rsp_valid high; the receiver cannot stall, so it must
// take each response as it appears. A push is taken without raising busy,
// and its response appears in the cycle after it is taken. A peek or pop
// with n stored entries reads slots 0 to max(n-2, 0) of the slot RAM one slot
// per cycle with busy high, and the response appears in the cycle after the
// scan ends. A pop that removes slot k then keeps busy high while entries
// k+1 to n-1 are copied down through the RAM's single read and write ports.
// Empty, full and unused-mode transactions respond in the cycle after
// acceptance without raising busy.
// ----------------------------------------------------------------------------
module min_priority_queue_scan import mpqs_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [ID_W-1:0]     req_entry_id,
   input  wire logic [PRI_W-1:0]    req_priority_req,
   output logic                     rsp_valid,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [ID_W-1:0]     rsp_out_id,
   output logic      [PRI_W-1:0]    rsp_out_priority
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [SLOT_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [SLOT_W-1:0] ram_rd_data;
   rsp_type           rsp_in;
   logic              rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ID_W-1:0]   rsp_out_id_ff;
   logic [PRI_W-1:0]  rsp_out_priority_ff;

   mpqs_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .mode         (req_mode),
      .entry_id     (req_entry_id),
      .priority_req (req_priority_req),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .rsp          (rsp_in)
   );

   mpqs_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff       <= rsp_in.status;
      rsp_out_id_ff       <= rsp_in.out_id;
      rsp_out_priority_ff <= rsp_in.out_priority;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_id       = rsp_out_id_ff;
   assign rsp_out_priority = rsp_out_priority_ff;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for min_priority_queue_scan
// Pushes, peeks, pops and unused-mode commands go through the start/busy
// handshake. A local model of the slot store predicts every response, and
// a monitor compares each response with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import mpqs_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
   localparam int RANDOM_CMDS = 1700;
   localparam int STEADY_TAIL = 200;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   entry_id;
      logic [PRI_W-1:0]  priority_val;
   } queue_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     out_id;
      logic [PRI_W-1:0]    out_priority;
   } queue_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [MODE_W-1:0]   req_mode = MODE_PUSH;
   logic [ID_W-1:0]     req_entry_id = '0;
   logic [PRI_W-1:0]    req_priority_req = '0;
   logic                busy;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_out_id;
   logic [PRI_W-1:0]    rsp_out_priority;

   // Commands waiting to be issued and responses the queue model predicts.
   queue_cmd_type pending_cmds[$];
   queue_rsp_type predicted_rsps[$];

   // Local copy of the queue contents.
   logic [ID_W-1:0]  model_id[QUEUE_DEPTH];
   logic [PRI_W-1:0] model_pri[QUEUE_DEPTH];
   int               model_count = 0;

   int error_count = 0;
   int cycle_count = 0;
   int total_cmds = 0;
   int issued_count = 0;
   int gap_left = 0;
   int plan_count = 0;

   always #5 clock = ~clock;

   min_priority_queue_scan #(
      .DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_entry_id(req_entry_id),
      .req_priority_req(req_priority_req),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_out_id(rsp_out_id),
      .rsp_out_priority(rsp_out_priority)
   );

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // Applies one command to the local queue and returns its response.
   function automatic queue_rsp_type predict_queue_op(input queue_cmd_type cmd);
      queue_rsp_type    rsp;
      int               best;
      logic [PRI_W-1:0] best_pri;
      rsp = '0;
      case (cmd.mode)
         MODE_PUSH: begin
            if (model_count >= QUEUE_DEPTH) begin
               rsp.status = STATUS_FULL;
            end else begin
               model_id[model_count] = cmd.entry_id;
               model_pri[model_count] = cmd.priority_val;
               model_count++;
            end
         end
         MODE_PEEK, MODE_POP: begin
            if (model_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               // The newest entry takes part in the search only when it is alone.
               best = 0;
               best_pri = model_pri[0];
               for (int i = 0; i + 1 < model_count; i++) begin
                  if (model_pri[i] < best_pri) begin
                     best_pri = model_pri[i];
                     best = i;
                  end
               end
               rsp.out_id = model_id[best];
               rsp.out_priority = model_pri[best];
               if (cmd.mode == MODE_POP) begin
                  for (int i = best; i + 1 < model_count; i++) begin
                     model_id[i] = model_id[i + 1];
                     model_pri[i] = model_pri[i + 1];
                  end
                  model_count--;
               end
            end
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   // Queues a command and tracks the fill level it leads to.
   task automatic add_cmd(input logic [MODE_W-1:0] mode, input int entry_id, input int pri);
      queue_cmd_type cmd;
      cmd.mode = mode;
      cmd.entry_id = entry_id[ID_W-1:0];
      cmd.priority_val = pri[PRI_W-1:0];
      pending_cmds.push_back(cmd);
      if (mode == MODE_PUSH && plan_count < QUEUE_DEPTH) plan_count++;
      if (mode == MODE_POP && plan_count > 0) plan_count--;
   endtask

   function automatic int random_priority();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return $urandom_range(0, 7);
      if (pick == 3) return ($urandom_range(0, 1) == 0) ? 0 : 16'hFFFF;
      return $urandom_range(0, 16'hFFFF);
   endfunction

   // Driver: presents commands, holds each until busy is low at an edge.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predicted_rsps.push_back(predict_queue_op(pending_cmds.pop_front()));
            issued_count++;
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
               start <= 1'b0;
            end else if (issued_count < total_cmds - STEADY_TAIL &&
                         $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(1, 4) - 1;
               start <= 1'b0;
            end else begin
               start <= 1'b1;
               req_mode <= pending_cmds[0].mode;
               req_entry_id <= pending_cmds[0].entry_id;
               req_priority_req <= pending_cmds[0].priority_val;
            end
         end
      end
   end

   // Monitor: every strobed response must match the oldest prediction.
   always @(posedge clock) begin
      queue_rsp_type want;
      if (!reset && rsp_valid) begin
         if (predicted_rsps.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_status, 0);
         end else begin
            want = predicted_rsps.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_out_id !== want.out_id)
               report_mismatch("out_id", rsp_out_id, want.out_id);
            if (rsp_out_priority !== want.out_priority)
               report_mismatch("out_priority", rsp_out_priority, want.out_priority);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int push_pct;
      int pick;

      // Directed part: empty guards, single entry, newest-entry exclusion,
      // a full queue, ties and the unused mode.
      add_cmd(MODE_PEEK, 8'hFF, 16'hFFFF);
      add_cmd(MODE_POP, 0, 0);
      add_cmd(MODE_NOP, 8'hAA, 16'h5555);
      add_cmd(MODE_PUSH, 8'hFF, 16'hFFFF);
      add_cmd(MODE_PEEK, 0, 0);
      add_cmd(MODE_POP, 0, 0);
      add_cmd(MODE_PUSH, 8'h01, 16'h8000);
      add_cmd(MODE_PUSH, 8'h00, 16'h0000);
      add_cmd(MODE_PEEK, 0, 0);
      for (int i = 0; i < QUEUE_DEPTH - 2; i++)
         add_cmd(MODE_PUSH, 8'h10 + i, (i % 3 == 0) ? 16'h0001 : 16'h7FFF + i);
      add_cmd(MODE_PUSH, 8'h55, 16'h0000);
      add_cmd(MODE_NOP, 0, 0);
      add_cmd(MODE_POP, 0, 0);
      add_cmd(MODE_POP, 0, 0);
      add_cmd(MODE_POP, 0, 0);

      // Random part: the push rate drifts so the queue fills and drains often.
      push_pct = 50;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (n % 40 == 0) begin
            pick = $urandom_range(0, 2);
            push_pct = (pick == 0) ? 20 : (pick == 1) ? 50 : 80;
         end
         pick = $urandom_range(0, 99);
         if (pick < 3)
            add_cmd(MODE_NOP, $urandom_range(0, 255), random_priority());
         else if (pick < 3 + push_pct)
            add_cmd(MODE_PUSH, $urandom_range(0, 255), random_priority());
         else if ($urandom_range(0, 3) == 0)
            add_cmd(MODE_PEEK, $urandom_range(0, 255), random_priority());
         else
            add_cmd(MODE_POP, $urandom_range(0, 255), random_priority());
      end
      total_cmds = pending_cmds.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || predicted_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
src/mpqs_pkg.sv
src/mpqs_ram.sv
src/mpqs_ctrl.sv
src/min_priority_queue_scan.sv
tb/sv/tb_top.sv
